@@ hw/rtl/mcoc_pkg.sv @@
`timescale 1ns / 1ps

package mcoc_pkg;

  localparam int MAX_DIM        = 16384;
  localparam int MAX_LEVELS_DEF = 15;

  // dimension width follows from the largest base dimension
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int PAD_W    = DIM_W + 1;
  localparam int BLK_W    = 5;
  localparam int PB_W     = 8;
  localparam int LVL_W    = 4;
  localparam int BYTE_W   = 48;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = $clog2(DIM_W);
  localparam int BITLEN_W = $clog2(DIM_W + 1);

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_W   = 4'd0,
    REG_BASE_H   = 4'd1,
    REG_BASE_D   = 4'd2,
    REG_PIX_BITS = 4'd3,
    REG_BLOCKED  = 4'd4,
    REG_BLK_W    = 4'd5,
    REG_BLK_H    = 4'd6,
    REG_BLK_D    = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] base_w;
    logic [DIM_W-1:0] base_h;
    logic [DIM_W-1:0] base_d;
    logic [PB_W-1:0]  pixel_bits;
    logic             is_blocked;
    logic [BLK_W-1:0] blk_w;
    logic [BLK_W-1:0] blk_h;
    logic [BLK_W-1:0] blk_d;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_PAD,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic             load_dims;
    logic             div_step;
    logic             pad;
    logic             mul1;
    logic             mul2;
    logic             mul3;
    logic             acc;
    logic             out_load;
    logic [LVL_W-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    logic pad_en;
  } sts_t;

endpackage

@@ hw/rtl/mip_chain_offset_calc.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_mip_level
// out      output     out_valid / out_ready  out_level_offset, out_level_bytes,
//                                            out_level_width/height/depth, out_level_count
// cfg      input      cfg_valid / cfg_ready  cfg_addr, cfg_data
//
// one query walks levels 0..L through a shared size unit: per level load, pad,
// three multiply steps and accumulate, with 15 remainder steps between load and
// pad when block padding is on
// synchronous active-low reset clears the controller and restores default registers
// cfg_ready is always high; a stalled result sits in the output register, a new
// query is taken meanwhile and its result waits until that register frees up

module mip_chain_offset_calc #(
  parameter int MAX_LEVELS = mcoc_pkg::MAX_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // query channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mcoc_pkg::LVL_W-1:0]  in_mip_level,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mcoc_pkg::BYTE_W-1:0] out_level_offset,
  output logic [mcoc_pkg::BYTE_W-1:0] out_level_bytes,
  output logic [mcoc_pkg::DIM_W-1:0]  out_level_width,
  output logic [mcoc_pkg::DIM_W-1:0]  out_level_height,
  output logic [mcoc_pkg::DIM_W-1:0]  out_level_depth,
  output logic [mcoc_pkg::LVL_W-1:0]  out_level_count,
  // register write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mcoc_pkg::IDX_W-1:0]  cfg_addr,
  input  logic [mcoc_pkg::DIM_W-1:0]  cfg_data
);

  mcoc_pkg::cfg_t cfg;
  mcoc_pkg::cmd_t cmd;
  mcoc_pkg::sts_t sts;

  // register file, written on a cfg transfer to one of its eight addresses
  mcoc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: level loop, remainder step count, output register handshake
  mcoc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mip_level (in_mip_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // size unit: shift and clamp, block padding, product chain, offset sum
  mcoc_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk              (clk),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .out_level_offset (out_level_offset),
    .out_level_bytes  (out_level_bytes),
    .out_level_width  (out_level_width),
    .out_level_height (out_level_height),
    .out_level_depth  (out_level_depth),
    .out_level_count  (out_level_count)
  );

endmodule

@@ hw/rtl/mcoc_cfg_regs.sv @@
`timescale 1ns / 1ps

module mcoc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mcoc_pkg::IDX_W-1:0] cfg_addr,
  input  logic [mcoc_pkg::DIM_W-1:0] cfg_data,
  output mcoc_pkg::cfg_t             cfg
);

  mcoc_pkg::cfg_t cfg_r;
  mcoc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        mcoc_pkg::REG_BASE_W:   cfg_nxt.base_w     = cfg_data;
        mcoc_pkg::REG_BASE_H:   cfg_nxt.base_h     = cfg_data;
        mcoc_pkg::REG_BASE_D:   cfg_nxt.base_d     = cfg_data;
        mcoc_pkg::REG_PIX_BITS: cfg_nxt.pixel_bits = cfg_data[mcoc_pkg::PB_W-1:0];
        mcoc_pkg::REG_BLOCKED:  cfg_nxt.is_blocked = cfg_data[0];
        mcoc_pkg::REG_BLK_W:    cfg_nxt.blk_w      = cfg_data[mcoc_pkg::BLK_W-1:0];
        mcoc_pkg::REG_BLK_H:    cfg_nxt.blk_h      = cfg_data[mcoc_pkg::BLK_W-1:0];
        mcoc_pkg::REG_BLK_D:    cfg_nxt.blk_d      = cfg_data[mcoc_pkg::BLK_W-1:0];
        default:                cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_w     <= mcoc_pkg::DIM_W'(1);
      cfg_r.base_h     <= mcoc_pkg::DIM_W'(1);
      cfg_r.base_d     <= mcoc_pkg::DIM_W'(1);
      cfg_r.pixel_bits <= mcoc_pkg::PB_W'(32);
      cfg_r.is_blocked <= 1'b0;
      cfg_r.blk_w      <= mcoc_pkg::BLK_W'(1);
      cfg_r.blk_h      <= mcoc_pkg::BLK_W'(1);
      cfg_r.blk_d      <= mcoc_pkg::BLK_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/mcoc_ctrl.sv @@
`timescale 1ns / 1ps

module mcoc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mcoc_pkg::LVL_W-1:0] in_mip_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  mcoc_pkg::sts_t             sts,
  output mcoc_pkg::cmd_t             cmd
);

  mcoc_pkg::state_t state_r, state_nxt;

  logic [mcoc_pkg::LVL_W-1:0] target_r, target_nxt;
  logic [mcoc_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic [mcoc_pkg::CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_free;
  logic                       last_lvl;
  logic                       div_last;

  assign out_free  = !out_valid_r || out_ready;
  assign last_lvl  = (lvl_r == target_r);
  assign div_last  = (div_cnt_r == mcoc_pkg::CNT_W'(mcoc_pkg::DIM_W - 1));
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcoc_pkg::S_IDLE: if (in_valid) state_nxt = mcoc_pkg::S_LOAD;
      mcoc_pkg::S_LOAD: state_nxt = sts.pad_en ? mcoc_pkg::S_DIV : mcoc_pkg::S_PAD;
      mcoc_pkg::S_DIV:  if (div_last) state_nxt = mcoc_pkg::S_PAD;
      mcoc_pkg::S_PAD:  state_nxt = mcoc_pkg::S_MUL1;
      mcoc_pkg::S_MUL1: state_nxt = mcoc_pkg::S_MUL2;
      mcoc_pkg::S_MUL2: state_nxt = mcoc_pkg::S_MUL3;
      mcoc_pkg::S_MUL3: state_nxt = mcoc_pkg::S_ACC;
      mcoc_pkg::S_ACC:  state_nxt = last_lvl ? mcoc_pkg::S_DONE : mcoc_pkg::S_LOAD;
      mcoc_pkg::S_DONE: if (out_free) state_nxt = mcoc_pkg::S_IDLE;
      default:          state_nxt = mcoc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.lvl      = lvl_r;
    in_ready     = 1'b0;
    target_nxt   = target_r;
    lvl_nxt      = lvl_r;
    div_cnt_nxt  = div_cnt_r;
    case (state_r)
      mcoc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          target_nxt = in_mip_level;
          lvl_nxt    = '0;
        end
      end
      mcoc_pkg::S_LOAD: begin
        cmd.load_dims = 1'b1;
        div_cnt_nxt   = '0;
      end
      mcoc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
      end
      mcoc_pkg::S_PAD:  cmd.pad  = 1'b1;
      mcoc_pkg::S_MUL1: cmd.mul1 = 1'b1;
      mcoc_pkg::S_MUL2: cmd.mul2 = 1'b1;
      mcoc_pkg::S_MUL3: cmd.mul3 = 1'b1;
      mcoc_pkg::S_ACC: begin
        if (!last_lvl) begin
          cmd.acc = 1'b1;
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      mcoc_pkg::S_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcoc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      target_r    <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      target_r    <= target_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/mcoc_dp.sv @@
`timescale 1ns / 1ps

module mcoc_dp #(
  parameter int MAX_LEVELS = mcoc_pkg::MAX_LEVELS_DEF
) (
  input  logic                        clk,
  input  mcoc_pkg::cfg_t              cfg,
  input  mcoc_pkg::cmd_t              cmd,
  output mcoc_pkg::sts_t              sts,
  output logic [mcoc_pkg::BYTE_W-1:0] out_level_offset,
  output logic [mcoc_pkg::BYTE_W-1:0] out_level_bytes,
  output logic [mcoc_pkg::DIM_W-1:0]  out_level_width,
  output logic [mcoc_pkg::DIM_W-1:0]  out_level_height,
  output logic [mcoc_pkg::DIM_W-1:0]  out_level_depth,
  output logic [mcoc_pkg::LVL_W-1:0]  out_level_count
);

  localparam int DW  = mcoc_pkg::DIM_W;
  localparam int PW  = mcoc_pkg::PAD_W;
  localparam int BW  = mcoc_pkg::BLK_W;
  localparam int YW  = mcoc_pkg::BYTE_W;
  localparam int P2W = 3 * PW;
  localparam int P3W = P2W + mcoc_pkg::PB_W;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] base,
                                              input logic [mcoc_pkg::LVL_W-1:0] lvl);
    logic [DW-1:0] v;
    v = base >> lvl;
    return (v == '0) ? DW'(1) : v;
  endfunction

  function automatic logic [BW-1:0] eff_blk(input logic en, input logic [BW-1:0] blk);
    return (!en || blk == '0) ? BW'(1) : blk;
  endfunction

  // one restoring step: bring in the next dividend bit, subtract if it fits
  function automatic logic [BW-1:0] rem_step(input logic [BW-1:0] rem, input logic b,
                                            input logic [BW-1:0] blk);
    logic [BW:0] t;
    t = {rem, b};
    return (t >= {1'b0, blk}) ? BW'(t - {1'b0, blk}) : BW'(t);
  endfunction

  function automatic logic [PW-1:0] pad_dim(input logic [DW-1:0] v, input logic [BW-1:0] r,
                                           input logic [BW-1:0] blk);
    return (r == '0) ? {1'b0, v} : ({1'b0, v} + PW'(blk) - PW'(r));
  endfunction

  logic [BW-1:0] bw, bh, bd;

  logic [DW-1:0]  dw_r, dh_r, dd_r;
  logic [DW-1:0]  qw_r, qh_r, qd_r;
  logic [BW-1:0]  rw_r, rh_r, rd_r;
  logic [PW-1:0]  pw_r, ph_r, pd_r;
  logic [2*PW-1:0] p1_r;
  logic [P2W-1:0] p2_r;
  logic [P3W-1:0] p3;
  logic [YW-1:0]  bytes_r;
  logic [YW-1:0]  off_r;

  logic [DW-1:0]                      big;
  logic [mcoc_pkg::BITLEN_W-1:0]      bitlen;
  logic [mcoc_pkg::LVL_W-1:0]         count;

  assign sts.pad_en = cfg.is_blocked;

  assign bw = eff_blk(cfg.is_blocked, cfg.blk_w);
  assign bh = eff_blk(cfg.is_blocked, cfg.blk_h);
  assign bd = eff_blk(cfg.is_blocked, cfg.blk_d);

  assign p3 = p2_r * cfg.pixel_bits;

  // level count: bit length of the largest base dimension, clamped
  always_comb begin
    big = cfg.base_w;
    if (cfg.base_h > big) big = cfg.base_h;
    if (cfg.base_d > big) big = cfg.base_d;
    bitlen = '0;
    for (int i = 0; i < DW; i++) begin
      if (big[i]) bitlen = mcoc_pkg::BITLEN_W'(i + 1);
    end
    if (bitlen == '0) begin
      count = mcoc_pkg::LVL_W'(1);
    end else if (int'(bitlen) > MAX_LEVELS) begin
      count = mcoc_pkg::LVL_W'(MAX_LEVELS);
    end else begin
      count = mcoc_pkg::LVL_W'(bitlen);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      off_r <= '0;
    end else if (cmd.acc) begin
      off_r <= off_r + bytes_r;
    end

    if (cmd.load_dims) begin
      dw_r <= clamp_dim(cfg.base_w, cmd.lvl);
      dh_r <= clamp_dim(cfg.base_h, cmd.lvl);
      dd_r <= clamp_dim(cfg.base_d, cmd.lvl);
      qw_r <= clamp_dim(cfg.base_w, cmd.lvl);
      qh_r <= clamp_dim(cfg.base_h, cmd.lvl);
      qd_r <= clamp_dim(cfg.base_d, cmd.lvl);
      rw_r <= '0;
      rh_r <= '0;
      rd_r <= '0;
    end else if (cmd.div_step) begin
      rw_r <= rem_step(rw_r, qw_r[DW-1], bw);
      rh_r <= rem_step(rh_r, qh_r[DW-1], bh);
      rd_r <= rem_step(rd_r, qd_r[DW-1], bd);
      qw_r <= {qw_r[DW-2:0], 1'b0};
      qh_r <= {qh_r[DW-2:0], 1'b0};
      qd_r <= {qd_r[DW-2:0], 1'b0};
    end

    if (cmd.pad) begin
      pw_r <= pad_dim(dw_r, rw_r, bw);
      ph_r <= pad_dim(dh_r, rh_r, bh);
      pd_r <= pad_dim(dd_r, rd_r, bd);
    end

    if (cmd.mul1) p1_r <= pw_r * ph_r;
    if (cmd.mul2) p2_r <= p1_r * pd_r;
    if (cmd.mul3) bytes_r <= p3[YW+2:3];

    if (cmd.out_load) begin
      out_level_offset <= off_r;
      out_level_bytes  <= bytes_r;
      out_level_width  <= dw_r;
      out_level_height <= dh_r;
      out_level_depth  <= dd_r;
      out_level_count  <= count;
    end
  end

endmodule

@@ hw/rtl/mcoc_chk.sv @@
`timescale 1ns / 1ps

module mcoc_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mcoc_pkg::BYTE_W-1:0] out_level_offset,
  input logic [mcoc_pkg::BYTE_W-1:0] out_level_bytes,
  input logic [mcoc_pkg::DIM_W-1:0]  out_level_width,
  input logic [mcoc_pkg::DIM_W-1:0]  out_level_height,
  input logic [mcoc_pkg::DIM_W-1:0]  out_level_depth
);

  // a held result keeps its offset, bytes and width
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level_offset)
      && $stable(out_level_bytes) && $stable(out_level_width))
    else $error("result changed while stalled");

  // nothing comes out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one query at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("query taken while busy");

  // level dimensions are clamped to at least one
  a_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_width != '0 && out_level_height != '0
      && out_level_depth != '0)
    else $error("zero level dimension");

endmodule

bind mip_chain_offset_calc mcoc_chk u_mcoc_chk (.*);
